FILE: hw/rtl/ttc_pkg.sv
// Shared types and constants for the triangle texture coordinate pipeline.
// Used by triangle_texture_coordinates; the arithmetic submodules are generic.
`timescale 1ns / 1ps

package ttc_pkg;

    localparam int TTC_FRAC_BITS = 8;
    localparam int TTC_COORD_W   = 16;
    localparam int TTC_LEN_W     = 16;
    localparam int TTC_CFG_IDX_W = 1;
    localparam int TTC_SQ_W      = 34;   // sum of three squared 16-bit distances
    localparam int TTC_ROOT_W    = 17;
    localparam int TTC_MAG_W     = 35;   // magnitude of a law-of-cosines numerator
    localparam int TTC_DIV_QW    = 19;   // quotient bits of the three parallel divides
    localparam int TTC_OUT_QW    = 16;

    localparam logic [TTC_LEN_W-1:0]  TTC_LEN_RESET = 16'd256;
    localparam logic [TTC_DIV_QW-1:0] TTC_P_MAX     = 19'h40000;

    localparam logic [TTC_CFG_IDX_W-1:0] TTC_CFG_LEN_S = 1'b0;
    localparam logic [TTC_CFG_IDX_W-1:0] TTC_CFG_LEN_T = 1'b1;

    // Side data that travels with the first square root.
    typedef struct packed {
        logic [TTC_SQ_W-1:0]  a2;
        logic                 neg;
        logic [TTC_MAG_W-1:0] mag1;
        logic [TTC_MAG_W-1:0] mag2;
        logic                 deg;
    } t_geo;

    // Finished fields that travel with the second square root and divide.
    typedef struct packed {
        logic                  deg;
        logic [TTC_OUT_QW-1:0] second_s;
        logic [TTC_OUT_QW-1:0] third_s;
    } t_part;

endpackage

FILE: hw/rtl/ttc_sqrt_pipe.sv
// Pipelined integer square root, one result bit per register stage.
// Generic; carries an opaque side vector alongside the radicand.
`timescale 1ns / 1ps

module ttc_sqrt_pipe #(
    parameter int NW = 34,
    parameter int SW = 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_vld,
    input  logic [NW-1:0]           i_rad,
    input  logic [SW-1:0]           i_side,
    output logic                    o_vld,
    output logic [(NW+1)/2-1:0]     o_root,
    output logic [SW-1:0]           o_side
);

    localparam int RW = (NW + 1) / 2;
    localparam int VW = 2 * RW;

    logic          r_vld  [RW];
    logic [VW:0]   r_rem  [RW];
    logic [RW-1:0] r_root [RW];
    logic [SW-1:0] r_side [RW];

    genvar j;
    generate
        for (j = 0; j < RW; j++) begin : g_stage
            localparam int K = RW - 1 - j;
            logic          w_vld;
            logic [VW:0]   w_rem;
            logic [RW-1:0] w_root;
            logic [SW-1:0] w_side;
            logic [VW:0]   w_trial;
            logic          w_take;
            logic [VW:0]   n_rem;
            logic [RW-1:0] n_root;

            if (j == 0) begin : g_in
                assign w_vld  = i_vld;
                assign w_rem  = (VW+1)'(i_rad);
                assign w_root = '0;
                assign w_side = i_side;
            end else begin : g_chain
                assign w_vld  = r_vld[j-1];
                assign w_rem  = r_rem[j-1];
                assign w_root = r_root[j-1];
                assign w_side = r_side[j-1];
            end

            // (R + 2^K)^2 - R^2 = R * 2^(K+1) + 2^(2K); R has no bits below K+1.
            assign w_trial = ((VW+1)'(w_root) << (K + 1)) | ((VW+1)'(1) << (2 * K));
            assign w_take  = w_rem >= w_trial;
            assign n_rem   = w_take ? w_rem - w_trial : w_rem;
            assign n_root  = w_take ? (w_root | (RW'(1) << K)) : w_root;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[j] <= 1'b0;
                end else if (i_en) begin
                    r_vld[j] <= w_vld;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j]  <= n_rem;
                    r_root[j] <= n_root;
                    r_side[j] <= w_side;
                end
            end
        end
    endgenerate

    assign o_vld  = r_vld[RW-1];
    assign o_root = r_root[RW-1];
    assign o_side = r_side[RW-1];

endmodule

FILE: hw/rtl/ttc_div_pipe.sv
// Pipelined restoring divider: an input register, then one quotient bit per register stage.
// Generic; flags quotients that do not fit in QW bits and carries a side vector.
`timescale 1ns / 1ps

module ttc_div_pipe #(
    parameter int NW = 32,
    parameter int DW = 16,
    parameter int QW = 16,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_vld,
    output logic [QW-1:0] o_quo,
    output logic          o_ovf,
    output logic [SW-1:0] o_side
);

    localparam int W = (NW > DW + QW) ? NW : DW + QW;

    logic          r_vld  [QW+1];
    logic [W-1:0]  r_rem  [QW+1];
    logic [DW-1:0] r_den  [QW+1];
    logic [QW-1:0] r_quo  [QW+1];
    logic          r_ovf  [QW+1];
    logic [SW-1:0] r_side [QW+1];

    logic n_ovf;

    // A zero divisor with a nonzero dividend counts as overflow.
    assign n_ovf = ((W+1)'(i_num) >= ((W+1)'(i_den) << QW)) && (i_num != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= W'(i_num);
            r_den[0]  <= i_den;
            r_quo[0]  <= '0;
            r_ovf[0]  <= n_ovf;
            r_side[0] <= i_side;
        end
    end

    genvar j;
    generate
        for (j = 0; j < QW; j++) begin : g_stage
            localparam int I = QW - 1 - j;
            logic [W-1:0]  n_sub;
            logic          n_take;
            logic [W-1:0]  n_rem;
            logic [QW-1:0] n_quo;

            assign n_sub  = W'(r_den[j]) << I;
            assign n_take = (r_rem[j] >= n_sub) && (r_den[j] != '0);
            assign n_rem  = n_take ? r_rem[j] - n_sub : r_rem[j];
            assign n_quo  = n_take ? (r_quo[j] | (QW'(1) << I)) : r_quo[j];

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[j+1] <= 1'b0;
                end else if (i_en) begin
                    r_vld[j+1] <= r_vld[j];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j+1]  <= n_rem;
                    r_den[j+1]  <= r_den[j];
                    r_quo[j+1]  <= n_quo;
                    r_ovf[j+1]  <= r_ovf[j];
                    r_side[j+1] <= r_side[j];
                end
            end
        end
    endgenerate

    assign o_vld  = r_vld[QW];
    assign o_quo  = r_quo[QW];
    assign o_ovf  = r_ovf[QW];
    assign o_side = r_side[QW];

endmodule

FILE: hw/rtl/triangle_texture_coordinates.sv
// Top level: texture coordinates of a triangle by the law of cosines.
// Depends on ttc_pkg, ttc_sqrt_pipe and ttc_div_pipe.
//
//  Channel   Direction  Payload
//  s_axis    in         tdata: ax, ay, az, bx, by, bz, cx, cy, cz (16 bits each)
//  m_axis    out        tdata: second_s, third_s, third_t; tuser: degenerate
//  cfg       in         write: idx 0 texture_length_s, idx 1 texture_length_t
//
// One item is accepted per cycle unless a result is held at the output.
// Most of the pipeline depth lies in the two 17-stage square roots, the 20-stage divide
// that yields a*cosB and the 17-stage divide for the t coordinate.
// Reset is synchronous and clears valid bits and both length registers to 1.0.
// When a result is held at the output, the whole pipeline freezes in place.
`timescale 1ns / 1ps

module triangle_texture_coordinates #(
    parameter int FRAC_BITS = ttc_pkg::TTC_FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // ax, ay, az, bx, by, bz, cx, cy, cz from bit 0 up
    input  logic [9*ttc_pkg::TTC_COORD_W-1:0] i_s_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // second_s, third_s, third_t from bit 0 up
    output logic [3*ttc_pkg::TTC_OUT_QW-1:0]  o_m_axis_tdata,
    // degenerate
    output logic [0:0]                        o_m_axis_tuser,
    input  logic                              i_cfg_we,
    input  logic [ttc_pkg::TTC_CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ttc_pkg::TTC_LEN_W-1:0]     i_cfg_data
);

    import ttc_pkg::*;

    localparam int NS_W    = TTC_ROOT_W + FRAC_BITS;
    localparam int NT_W    = TTC_MAG_W + FRAC_BITS;
    localparam int DS_W    = TTC_ROOT_W + TTC_LEN_W + 1;
    localparam int DP_W    = TTC_ROOT_W + 1;
    localparam int P2_W    = 2 * TTC_DIV_QW;
    localparam int GEO_W   = $bits(t_geo);
    localparam int PART_W  = $bits(t_part);
    // Coordinate indexes of the two ends of each difference: sides a, b, c.
    localparam int P_HI [9] = '{6, 7, 8, 6, 7, 8, 3, 4, 5};
    localparam int P_LO [9] = '{3, 4, 5, 0, 1, 2, 0, 1, 2};

    logic                 w_en;
    logic [TTC_LEN_W-1:0] r_len_s;
    logic [TTC_LEN_W-1:0] r_len_t;

    assign w_en            = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_s <= TTC_LEN_RESET;
            r_len_t <= TTC_LEN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                TTC_CFG_LEN_S: r_len_s <= i_cfg_data;
                TTC_CFG_LEN_T: r_len_t <= i_cfg_data;
                default:       r_len_s <= r_len_s;
            endcase
        end
    end

    // Stage 1: coordinate differences as magnitudes.
    logic [TTC_COORD_W-1:0] w_crd [9];
    logic signed [16:0]     w_diff [9];
    logic [15:0]            n_s1_mag [9];
    logic [15:0]            r_s1_mag [9];
    logic                   r_s1_vld;

    genvar k;
    generate
        for (k = 0; k < 9; k++) begin : g_diff
            assign w_crd[k]    = i_s_axis_tdata[k*TTC_COORD_W +: TTC_COORD_W];
            assign w_diff[k]   = $signed({w_crd[P_HI[k]][15], w_crd[P_HI[k]]})
                               - $signed({w_crd[P_LO[k]][15], w_crd[P_LO[k]]});
            assign n_s1_mag[k] = w_diff[k][16] ? 16'(-w_diff[k]) : w_diff[k][15:0];
        end
    endgenerate

    // Stage 2: squares.
    logic [31:0] r_s2_sq [9];
    logic        r_s2_vld;

    // Stage 3: squared side lengths and the two cosine numerators.
    logic [TTC_SQ_W-1:0]  n_a2, n_b2, n_c2;
    logic signed [35:0]   n_num1, n_num2;
    t_geo                 n_geo;
    t_geo                 r_s3_geo;
    logic [TTC_SQ_W-1:0]  r_s3_c2;
    logic                 r_s3_vld;

    always_comb begin
        n_a2   = 34'(r_s2_sq[0]) + 34'(r_s2_sq[1]) + 34'(r_s2_sq[2]);
        n_b2   = 34'(r_s2_sq[3]) + 34'(r_s2_sq[4]) + 34'(r_s2_sq[5]);
        n_c2   = 34'(r_s2_sq[6]) + 34'(r_s2_sq[7]) + 34'(r_s2_sq[8]);
        n_num1 = $signed(36'(n_c2)) + $signed(36'(n_b2)) - $signed(36'(n_a2));
        n_num2 = $signed(36'(n_a2)) + $signed(36'(n_c2)) - $signed(36'(n_b2));
        n_geo.a2   = n_a2;
        n_geo.neg  = n_num1[35];
        n_geo.mag1 = n_num1[35] ? 35'(-n_num1) : n_num1[34:0];
        n_geo.mag2 = n_num2[35] ? 35'(-n_num2) : n_num2[34:0];
        n_geo.deg  = (n_a2 == '0) || (n_c2 == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld <= i_s_axis_tvalid;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 9; i++) begin
                r_s1_mag[i] <= n_s1_mag[i];
                r_s2_sq[i]  <= 32'(r_s1_mag[i]) * 32'(r_s1_mag[i]);
            end
            r_s3_geo <= n_geo;
            r_s3_c2  <= n_c2;
        end
    end

    // Length of side c.
    logic                  w_sqc_vld;
    logic [TTC_ROOT_W-1:0] w_sqc_root;
    logic [GEO_W-1:0]      w_sqc_side;
    t_geo                  w_geo;

    ttc_sqrt_pipe #(.NW(TTC_SQ_W), .SW(GEO_W)) u_sqrt_c (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (r_s3_vld),
        .i_rad  (r_s3_c2),
        .i_side (r_s3_geo),
        .o_vld  (w_sqc_vld),
        .o_root (w_sqc_root),
        .o_side (w_sqc_side)
    );

    assign w_geo = w_sqc_side;

    // Divider operands.
    logic                 r_m_vld;
    logic [NS_W-1:0]      r_m_num_s;
    logic [DS_W-1:0]      r_m_den_s;
    logic [NT_W-1:0]      r_m_num_t;
    logic [TTC_MAG_W-1:0] r_m_num_p;
    logic [DP_W-1:0]      r_m_den_p;
    logic [TTC_SQ_W-1:0]  r_m_a2;
    logic                 r_m_neg;
    logic                 r_m_deg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (w_en) begin
            r_m_vld <= w_sqc_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m_num_s <= {w_sqc_root, {FRAC_BITS{1'b0}}};
            r_m_den_s <= DS_W'({w_sqc_root, 1'b0}) * DS_W'(r_len_s);
            r_m_num_t <= {w_geo.mag1, {FRAC_BITS{1'b0}}};
            r_m_num_p <= w_geo.mag2;
            r_m_den_p <= {w_sqc_root, 1'b0};
            r_m_a2    <= w_geo.a2;
            r_m_neg   <= w_geo.neg;
            r_m_deg   <= w_geo.deg;
        end
    end

    // Three divides side by side: c/Ls, (c - a cosB)/Ls and a cosB.
    logic                  w_d1_vld, w_d2_vld, w_d3_vld;
    logic [TTC_DIV_QW-1:0] w_d1_quo, w_d2_quo, w_d3_quo;
    logic                  w_d1_ovf, w_d2_ovf, w_d3_ovf;
    logic [0:0]            w_d1_deg, w_d2_neg;
    logic [TTC_SQ_W-1:0]   w_d3_a2;

    ttc_div_pipe #(.NW(NS_W), .DW(TTC_LEN_W), .QW(TTC_DIV_QW), .SW(1)) u_div_second_s (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (r_m_vld),
        .i_num  (r_m_num_s),
        .i_den  (r_len_s),
        .i_side (r_m_deg),
        .o_vld  (w_d1_vld),
        .o_quo  (w_d1_quo),
        .o_ovf  (w_d1_ovf),
        .o_side (w_d1_deg)
    );

    ttc_div_pipe #(.NW(NT_W), .DW(DS_W), .QW(TTC_DIV_QW), .SW(1)) u_div_third_s (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (r_m_vld),
        .i_num  (r_m_num_t),
        .i_den  (r_m_den_s),
        .i_side (r_m_neg),
        .o_vld  (w_d2_vld),
        .o_quo  (w_d2_quo),
        .o_ovf  (w_d2_ovf),
        .o_side (w_d2_neg)
    );

    ttc_div_pipe #(.NW(TTC_MAG_W), .DW(DP_W), .QW(TTC_DIV_QW), .SW(TTC_SQ_W)) u_div_p (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (r_m_vld),
        .i_num  (r_m_num_p),
        .i_den  (r_m_den_p),
        .i_side (r_m_a2),
        .o_vld  (w_d3_vld),
        .o_quo  (w_d3_quo),
        .o_ovf  (w_d3_ovf),
        .o_side (w_d3_a2)
    );

    // Saturation of the s results and clamping of a cosB.
    logic                  w_s3_big;
    logic [TTC_OUT_QW-1:0] w_s3_mag;
    t_part                 n_p1_part;
    logic [TTC_DIV_QW-1:0] n_p1_p;
    logic                  r_p1_vld;
    t_part                 r_p1_part;
    logic [TTC_DIV_QW-1:0] r_p1_p;
    logic [TTC_SQ_W-1:0]   r_p1_a2;
    logic                  r_p2_vld;
    t_part                 r_p2_part;
    logic [P2_W-1:0]       r_p2_p2;
    logic [TTC_SQ_W-1:0]   r_p2_a2;
    logic                  r_p3_vld;
    t_part                 r_p3_part;
    logic [TTC_SQ_W-1:0]   r_p3_rad;

    always_comb begin
        w_s3_big = w_d2_ovf || (w_d2_quo[TTC_DIV_QW-1:15] != '0);
        w_s3_mag = w_s3_big ? 16'h8000 : {1'b0, w_d2_quo[14:0]};
        n_p1_part.deg = w_d1_deg[0];
        n_p1_part.second_s = (w_d1_ovf || (w_d1_quo[TTC_DIV_QW-1:16] != '0))
                           ? 16'hFFFF : w_d1_quo[15:0];
        if (w_d2_neg[0]) begin
            n_p1_part.third_s = 16'(0) - w_s3_mag;
        end else begin
            n_p1_part.third_s = w_s3_big ? 16'h7FFF : w_s3_mag;
        end
        n_p1_p = (w_d3_ovf || (w_d3_quo > TTC_P_MAX)) ? TTC_P_MAX : w_d3_quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
            r_p3_vld <= 1'b0;
        end else if (w_en) begin
            r_p1_vld <= w_d3_vld;
            r_p2_vld <= r_p1_vld;
            r_p3_vld <= r_p2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1_part <= n_p1_part;
            r_p1_p    <= n_p1_p;
            r_p1_a2   <= w_d3_a2;
            r_p2_part <= r_p1_part;
            r_p2_p2   <= P2_W'(r_p1_p) * P2_W'(r_p1_p);
            r_p2_a2   <= r_p1_a2;
            r_p3_part <= r_p2_part;
            // A rounded-up a cosB can exceed a; the radicand then clamps to zero.
            r_p3_rad  <= (P2_W'(r_p2_a2) > r_p2_p2) ? r_p2_a2 - r_p2_p2[TTC_SQ_W-1:0] : '0;
        end
    end

    // a sinB and the t coordinate.
    logic                  w_sqt_vld;
    logic [TTC_ROOT_W-1:0] w_sqt_root;
    logic [PART_W-1:0]     w_sqt_side;
    logic                  w_dt_vld;
    logic [TTC_OUT_QW-1:0] w_dt_quo;
    logic                  w_dt_ovf;
    logic [PART_W-1:0]     w_dt_side;
    t_part                 w_fin;

    ttc_sqrt_pipe #(.NW(TTC_SQ_W), .SW(PART_W)) u_sqrt_t (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (r_p3_vld),
        .i_rad  (r_p3_rad),
        .i_side (r_p3_part),
        .o_vld  (w_sqt_vld),
        .o_root (w_sqt_root),
        .o_side (w_sqt_side)
    );

    ttc_div_pipe #(.NW(NS_W), .DW(TTC_LEN_W), .QW(TTC_OUT_QW), .SW(PART_W)) u_div_t (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (w_sqt_vld),
        .i_num  ({w_sqt_root, {FRAC_BITS{1'b0}}}),
        .i_den  (r_len_t),
        .i_side (w_sqt_side),
        .o_vld  (w_dt_vld),
        .o_quo  (w_dt_quo),
        .o_ovf  (w_dt_ovf),
        .o_side (w_dt_side)
    );

    assign w_fin = w_dt_side;

    // Output register.
    logic                    r_out_vld;
    logic [3*TTC_OUT_QW-1:0] r_out_data;
    logic                    r_out_deg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_dt_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_deg <= w_fin.deg;
            if (w_fin.deg) begin
                r_out_data <= '0;
            end else begin
                r_out_data <= {(w_dt_ovf ? 16'hFFFF : w_dt_quo), w_fin.third_s,
                               w_fin.second_s};
            end
        end
    end

    assign o_m_axis_tvalid   = r_out_vld;
    assign o_m_axis_tdata    = r_out_data;
    assign o_m_axis_tuser[0] = r_out_deg;

    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_d1_vld == w_d3_vld) && (w_d2_vld == w_d3_vld))
        else $error("parallel divide lanes out of step");

    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |-> o_m_axis_tdata == '0)
        else $error("degenerate item with nonzero coordinates");

    a_p_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p1_vld |-> r_p1_p <= TTC_P_MAX)
        else $error("a cosB above clamp");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(w_sqc_vld) && $stable(r_p3_rad))
        else $error("pipeline moved during stall");

endmodule
